// ===== rtl/priority_batch_command_queue_core_macros.svh =====
// Assertion macros used by the priority batch command queue datapath.
`ifndef PRIORITY_BATCH_COMMAND_QUEUE_CORE_MACROS_SVH
`define PRIORITY_BATCH_COMMAND_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PBCQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbcq assertion failed");

// Next-cycle implication, disabled in reset.
`define PBCQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbcq assertion failed");

`endif

// ===== rtl/pbcq_pkg.sv =====
// Package: types, codes and helpers of the priority batch command queue.
`timescale 1ns / 1ps
package pbcq_pkg;

    localparam int QUEUE_DEPTH_DEF     = 1024;
    localparam int MAX_BATCH_DEF       = 32;
    localparam int OVERFLOW_FACTOR_DEF = 20;

    localparam int REQ_W      = 2;
    localparam int BATCH_W    = 6;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd2;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_REFUSED  = 2'd2;

    localparam logic [7:0] FRAME_HEADER = 8'hCC;
    localparam logic [7:0] FRAME_TYPE   = 8'h01;
    localparam logic [7:0] COLOR_MAX    = 8'd255;

    localparam logic [BATCH_W-1:0] BATCH_RESET = 6'd16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd50;
    localparam logic [DELAY_W-1:0] DELAY_SAT   = 16'hFFFF;

    typedef struct packed {
        logic signed [7:0] prio;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic [7:0]        key;
    } cmd_t;

    typedef struct packed {
        logic       capture;
        logic       store;
        logic       emit_status;
        logic [1:0] status_code;
        logic       status_last;
        logic       tick;
        logic       clear;
        logic       rel_init;
        logic       rd;
        logic       insert;
        logic       emit_frame;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             enabled;
        logic             full;
        logic             reach;
        logic             tick_rel;
        logic             n_zero;
        logic             ins_done;
        logic             emit_last;
        logic             out_free;
    } ctrl_sts_t;

    function automatic logic [7:0] clamp_color(input logic signed [9:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 10'sd255)
            r = COLOR_MAX;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

// ===== rtl/pbcq_ctrl.sv =====
// Controller state machine of the priority batch command queue.
`timescale 1ns / 1ps
module pbcq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pbcq_pkg::ctrl_sts_t  sts,
    output pbcq_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_REL_INIT = 3'd2;
    localparam logic [2:0] S_READ     = 3'd3;
    localparam logic [2:0] S_INSERT   = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (sts.req)
                    pbcq_pkg::REQ_ADD:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit_status = 1'b1;
                            state_next      = S_IDLE;
                            if (!sts.enabled)
                            begin
                                cmd.status_code = pbcq_pkg::ST_REFUSED;
                                cmd.status_last = 1'b1;
                            end
                            else if (sts.full)
                            begin
                                cmd.status_code = pbcq_pkg::ST_DROPPED;
                                cmd.status_last = 1'b1;
                            end
                            else
                            begin
                                cmd.store       = 1'b1;
                                cmd.status_code = pbcq_pkg::ST_ACCEPTED;
                                cmd.status_last = !sts.reach;
                                if (sts.reach)
                                    state_next = S_REL_INIT;
                            end
                        end
                    end
                    pbcq_pkg::REQ_TICK:
                    begin
                        state_next = S_IDLE;
                        if (sts.enabled)
                        begin
                            cmd.tick = 1'b1;
                            if (sts.tick_rel)
                                state_next = S_REL_INIT;
                        end
                    end
                    pbcq_pkg::REQ_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_REL_INIT:
            begin
                cmd.rel_init = 1'b1;
                state_next   = sts.n_zero ? S_IDLE : S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = sts.ins_done ? S_EMIT : S_READ;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_frame = 1'b1;
                    if (sts.emit_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/pbcq_dp.sv =====
// Datapath: queue memory, batch sort buffer, timers, configuration and output register.
`timescale 1ns / 1ps
`include "priority_batch_command_queue_core_macros.svh"
module pbcq_dp #(
    parameter int QUEUE_DEPTH     = pbcq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_BATCH       = pbcq_pkg::MAX_BATCH_DEF,
    parameter int OVERFLOW_FACTOR = pbcq_pkg::OVERFLOW_FACTOR_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pbcq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbcq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [pbcq_pkg::REQ_W-1:0]        req_type,
    input  logic [7:0]                        led_key,
    input  logic signed [9:0]                 red_in,
    input  logic signed [9:0]                 green_in,
    input  logic signed [9:0]                 blue_in,
    input  logic signed [7:0]                 prio,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kind,
    output logic [1:0]                        status,
    output logic [7:0]                        frame_header,
    output logic [7:0]                        frame_type,
    output logic [7:0]                        out_key,
    output logic [7:0]                        out_red,
    output logic [7:0]                        out_green,
    output logic [7:0]                        out_blue,
    output logic                              last,
    input  pbcq_pkg::ctrl_cmd_t               cmd,
    output pbcq_pkg::ctrl_sts_t               sts
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BW = $clog2(MAX_BATCH + 1);
    localparam int IW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int DW = pbcq_pkg::DELAY_W;

    logic                             en_reg;
    logic [pbcq_pkg::BATCH_W-1:0]     bs_reg;
    logic [DW-1:0]                    md_reg;
    logic [PW-1:0]                    head_reg;
    logic [PW-1:0]                    tail_reg;
    logic [CW-1:0]                    fill_reg;
    logic [DW-1:0]                    since_reg;
    logic [DW-1:0]                    phase_reg;
    logic [pbcq_pkg::REQ_W-1:0]       req_reg;
    pbcq_pkg::cmd_t                   in_cmd_reg;
    pbcq_pkg::cmd_t                   rd_data_reg;
    pbcq_pkg::cmd_t                   cmd_mem [QUEUE_DEPTH];
    pbcq_pkg::cmd_t                   batch_buf_reg [MAX_BATCH];
    pbcq_pkg::cmd_t                   batch_buf_next [MAX_BATCH];
    logic [MAX_BATCH-1:0]             ge;
    logic [BW-1:0]                    n_reg;
    logic [BW-1:0]                    cnt_reg;
    logic [BW-1:0]                    idx_reg;
    logic                             out_valid_reg;
    logic                             out_kind_reg;
    logic [1:0]                       out_status_reg;
    logic                             out_last_reg;
    pbcq_pkg::cmd_t                   out_cmd_reg;

    logic [BW-1:0]                    eff;
    logic [DW-1:0]                    dly;
    logic [31:0]                      prod;
    logic [31:0]                      limit;
    logic [BW-1:0]                    n_calc;
    logic [DW-1:0]                    since_inc;
    logic [DW-1:0]                    phase_inc;
    logic                             fire;
    logic                             out_free;
    pbcq_pkg::cmd_t                   new_cmd;

    assign eff = (bs_reg == '0) ? BW'(1) :
                 (bs_reg > pbcq_pkg::BATCH_W'(MAX_BATCH)) ? BW'(MAX_BATCH) : BW'(bs_reg);
    assign dly   = (md_reg == '0) ? DW'(1) : md_reg;
    assign prod  = 32'(eff) * 32'(OVERFLOW_FACTOR);
    assign limit = (prod > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH) : prod;
    assign n_calc = (32'(fill_reg) < 32'(eff)) ? BW'(fill_reg) : eff;
    assign since_inc = (since_reg < pbcq_pkg::DELAY_SAT) ? since_reg + DW'(1) : since_reg;
    assign phase_inc = phase_reg + DW'(1);
    assign fire      = (phase_inc >= dly);
    assign out_free  = !out_valid_reg || !out_stall;

    assign new_cmd.key   = led_key;
    assign new_cmd.red   = pbcq_pkg::clamp_color(red_in);
    assign new_cmd.green = pbcq_pkg::clamp_color(green_in);
    assign new_cmd.blue  = pbcq_pkg::clamp_color(blue_in);
    assign new_cmd.prio  = prio;

    always_comb
    begin
        sts           = '0;
        sts.req       = req_reg;
        sts.enabled   = en_reg;
        sts.full      = (32'(fill_reg) >= limit);
        sts.reach     = (32'(fill_reg) + 32'd1 >= 32'(eff));
        sts.tick_rel  = fire && ((32'(fill_reg) >= 32'(eff)) ||
                                 ((fill_reg != '0) && (since_inc >= dly)));
        sts.n_zero    = (n_calc == '0);
        sts.ins_done  = (cnt_reg + BW'(1) == n_reg);
        sts.emit_last = (idx_reg + BW'(1) == n_reg);
        sts.out_free  = out_free;
    end

    // Stable insertion: slots holding a priority >= the new one keep their entry.
    genvar j;
    generate
        for (j = 0; j < MAX_BATCH; j++)
        begin : g_slot
            assign ge[j] = (BW'(j) < cnt_reg) &&
                           (batch_buf_reg[j].prio >= rd_data_reg.prio);
            if (j == 0)
            begin : g_first
                assign batch_buf_next[j] = ge[j] ? batch_buf_reg[j] : rd_data_reg;
            end
            else
            begin : g_rest
                assign batch_buf_next[j] = ge[j]     ? batch_buf_reg[j] :
                                           ge[j - 1] ? rd_data_reg : batch_buf_reg[j - 1];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            cmd_mem[tail_reg] <= in_cmd_reg;
        if (cmd.rd)
            rd_data_reg <= cmd_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg    <= req_type;
            in_cmd_reg <= new_cmd;
        end
        if (cmd.insert)
            batch_buf_reg <= batch_buf_next;
        if (cmd.emit_status || cmd.emit_frame)
        begin
            out_kind_reg   <= cmd.emit_frame;
            out_status_reg <= cmd.emit_frame ? pbcq_pkg::ST_ACCEPTED : cmd.status_code;
            out_last_reg   <= cmd.emit_frame ? sts.emit_last : cmd.status_last;
            out_cmd_reg    <= batch_buf_reg[idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b0;
            bs_reg        <= pbcq_pkg::BATCH_RESET;
            md_reg        <= pbcq_pkg::DELAY_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            since_reg     <= '0;
            phase_reg     <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pbcq_pkg::REG_ENABLE)
                begin
                    if (cfg_data[0] && !en_reg)
                    begin
                        since_reg <= '0;
                        phase_reg <= '0;
                    end
                    else if (!cfg_data[0] && en_reg)
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                        fill_reg <= '0;
                    end
                    en_reg <= cfg_data[0];
                end
                else if (cfg_index == pbcq_pkg::REG_BATCH)
                    bs_reg <= cfg_data[pbcq_pkg::BATCH_W-1:0];
                else if (cfg_index == pbcq_pkg::REG_DELAY)
                    md_reg <= cfg_data[DW-1:0];
            end

            if (cmd.store)
            begin
                tail_reg <= (tail_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
                fill_reg <= fill_reg + CW'(1);
            end
            if (cmd.clear)
            begin
                head_reg <= '0;
                tail_reg <= '0;
                fill_reg <= '0;
            end
            if (cmd.tick)
            begin
                since_reg <= since_inc;
                phase_reg <= fire ? '0 : phase_inc;
            end
            if (cmd.rel_init)
            begin
                n_reg   <= n_calc;
                cnt_reg <= '0;
                idx_reg <= '0;
                if (n_calc != '0)
                    since_reg <= '0;
            end
            if (cmd.rd)
            begin
                head_reg <= (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PW'(1);
                fill_reg <= fill_reg - CW'(1);
            end
            if (cmd.insert)
                cnt_reg <= cnt_reg + BW'(1);
            if (cmd.emit_frame)
                idx_reg <= idx_reg + BW'(1);

            if (cmd.emit_status || cmd.emit_frame)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;
    assign frame_header = out_kind_reg ? pbcq_pkg::FRAME_HEADER : 8'd0;
    assign frame_type   = out_kind_reg ? pbcq_pkg::FRAME_TYPE : 8'd0;
    assign out_key      = out_kind_reg ? out_cmd_reg.key : 8'd0;
    assign out_red      = out_kind_reg ? out_cmd_reg.red : 8'd0;
    assign out_green    = out_kind_reg ? out_cmd_reg.green : 8'd0;
    assign out_blue     = out_kind_reg ? out_cmd_reg.blue : 8'd0;

    `PBCQ_ASSERT_NOW(a_emit_free, cmd.emit_status || cmd.emit_frame, out_free)
    `PBCQ_ASSERT_NOW(a_insert_range, cmd.insert, cnt_reg < n_reg)
    `PBCQ_ASSERT_NOW(a_emit_range, cmd.emit_frame, idx_reg < n_reg)
    `PBCQ_ASSERT_NEXT(a_since_clear, cmd.rel_init && (n_calc != '0), since_reg == '0)

endmodule

// ===== rtl/priority_batch_command_queue_core.sv =====
// Top level of the priority batch command queue.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | in_valid / in_stall  | req_type led_key red_in green_in blue_in prio
//  output   | out_valid / out_stall| kind status frame_header frame_type out_key
//           |                      | out_red out_green out_blue last
//  config   | cfg_we               | cfg_index cfg_data
//
// One transaction at a time: accept, then the decide step (tick, clear, add status).
// A batch release of n entries runs a release setup step, then one queue memory read
// and one insertion step per entry, then emits one frame per entry.
// Output stalls hold the controller in its decide step (add status) or its emit step;
// the output register lets a new input transaction in while a result still waits.
// No clearing pass after reset.
`timescale 1ns / 1ps
module priority_batch_command_queue_core #(
    parameter int QUEUE_DEPTH     = pbcq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_BATCH       = pbcq_pkg::MAX_BATCH_DEF,
    parameter int OVERFLOW_FACTOR = pbcq_pkg::OVERFLOW_FACTOR_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pbcq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbcq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pbcq_pkg::REQ_W-1:0]        req_type,
    input  logic [7:0]                        led_key,
    input  logic signed [9:0]                 red_in,
    input  logic signed [9:0]                 green_in,
    input  logic signed [9:0]                 blue_in,
    input  logic signed [7:0]                 prio,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kind,
    output logic [1:0]                        status,
    output logic [7:0]                        frame_header,
    output logic [7:0]                        frame_type,
    output logic [7:0]                        out_key,
    output logic [7:0]                        out_red,
    output logic [7:0]                        out_green,
    output logic [7:0]                        out_blue,
    output logic                              last
);

    pbcq_pkg::ctrl_cmd_t cmd;
    pbcq_pkg::ctrl_sts_t sts;

    pbcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbcq_dp #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .MAX_BATCH       (MAX_BATCH),
        .OVERFLOW_FACTOR (OVERFLOW_FACTOR)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .led_key      (led_key),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .prio         (prio),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .status       (status),
        .frame_header (frame_header),
        .frame_type   (frame_type),
        .out_key      (out_key),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .last         (last),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
